@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every edge outside reset
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/msie_pkg.sv @@
// ----------------------------------------------------------------------------
// msie_pkg
// Types, opcodes and constants of the MIPS subset execute core.
// ----------------------------------------------------------------------------
package msie_pkg;

  localparam int unsigned DataWordsDef = 1024;
  localparam logic [31:0] StartPcRst   = 32'h0040_0000;
  localparam logic [31:0] DataBaseRst  = 32'h1000_0000;

  typedef enum logic [1:0] {
    CMD_EXEC = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_HALT = 3'd1,
    ST_UNSP = 3'd2,
    ST_PDEC = 3'd3,
    ST_PHEX = 3'd4
  } status_t;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BGTZ  = 6'd7;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LB    = 6'd32;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SB    = 6'd40;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;

  localparam logic [31:0] SYS_PDEC = 32'd1;
  localparam logic [31:0] SYS_EXIT = 32'd10;
  localparam logic [31:0] SYS_PHEX = 32'd34;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_A0 = 5'd4;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam int unsigned IdxDataBase = 1;

  // Decoded request carried from stage 1 to stage 2
  typedef struct packed {
    logic        ld_b;     // LB
    logic        ld_w;     // LW
    logic        st_b;     // SB
    logic        st_w;     // SW
    logic        rd_cmd;   // cmd 2
    logic        wr_cmd;   // cmd 1
    logic [1:0]  lane;
    logic [31:0] st_data;  // store source (rt or access_data)
  } mem_op_t;

endpackage

@@ rtl/core/mips_subset_instruction_execute_core.sv @@
// Stage 1 decodes and reads registers and data memory; stage 2 writes memory
//   and the output register. One request per cycle unless out_ready stalls.
// Reset: registers, PC (start_pc), halt flag cleared at once; then a clearing
//   pass zeroes every data memory word while in_ready stays low.
// ----------------------------------------------------------------------------
// mips_subset_instruction_execute_core
// Two-stage execute core for a MIPS32 subset with host memory access.
// ----------------------------------------------------------------------------
module mips_subset_instruction_execute_core #(
  parameter int unsigned DATA_WORDS = msie_pkg::DataWordsDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [31:0]              cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic [31:0]              in_instr_word,
  input  logic [31:0]              in_access_addr,
  input  logic [31:0]              in_access_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_status,
  output logic [31:0]              out_next_pc,
  output logic                     out_reg_written,
  output logic [4:0]               out_reg_index,
  output logic [31:0]              out_reg_value,
  output logic                     out_mem_written,
  output logic [31:0]              out_out_value
);
  import msie_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic [31:0] data_base_r;
  logic [31:0] pc_r, pc_nxt;
  logic        halt_r, halt_nxt;
  logic        clr_r;
  logic [AW:0] clr_cnt_r;

  // stage 2 registers
  logic          s2_v_r;
  mem_op_t       s2_op_r;
  logic [AW-1:0] s2_addr_r;
  logic [2:0]    s2_st_r;
  logic [31:0]   s2_npc_r;
  logic          s2_wr_r;
  logic [4:0]    s2_idx_r;
  logic [31:0]   s2_val_r;
  logic [31:0]   s2_outv_r;
  logic [31:0]   s2_fwd_r;   // forwarded word when read hit stage 2 write
  logic          s2_fwd_v_r;

  // output register
  logic        o_v_r;
  logic [2:0]  o_st_r;
  logic [31:0] o_npc_r, o_val_r, o_outv_r;
  logic        o_wr_r, o_mw_r;
  logic [4:0]  o_idx_r;

  logic adv2, acc;
  assign adv2     = !o_v_r || out_ready;
  assign in_ready = !clr_r && adv2;
  assign acc      = in_valid && in_ready;

  // ---------------- stage 1: decode and register read
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd;
  logic [31:0] simm, a, b, v0, a0, pc4, ea, base_addr, off;
  assign op   = in_instr_word[31:26];
  assign rs   = in_instr_word[25:21];
  assign rt   = in_instr_word[20:16];
  assign rd   = in_instr_word[15:11];
  assign fn   = in_instr_word[5:0];
  assign simm = {{16{in_instr_word[15]}}, in_instr_word[15:0]};

  // stage 2 writes the register file (loads and ALU results); forward its result
  logic        wb_we;
  logic [4:0]  wb_idx;
  logic [31:0] wb_val;
  logic [31:0] rfa, rfb, rfc;
  logic [31:0] ld_word, ld_val;
  logic [4:0]  ra_b_sel;

  msie_regfile u_rf (
    .clk(clk), .rst_n(rst_n),
    .ra_a(rs), .ra_b(ra_b_sel), .ra_c(REG_V0),
    .rd_a(rfa), .rd_b(rfb), .rd_c(rfc),
    .we(wb_we), .wa(wb_idx), .wd(wb_val)
  );

  // a0 read via port b when syscall (rt unused there)
  assign a = rfa;
  assign b = rfb;
  assign v0 = rfc;
  assign a0 = rfb;

  assign pc4 = pc_r + 32'd4;
  assign ea  = a + simm;
  assign base_addr = (in_cmd == CMD_EXEC) ? ea : in_access_addr;
  assign off = base_addr - data_base_r;

  assign ra_b_sel = (in_cmd == CMD_EXEC && op == OP_RTYPE && fn == FN_SYSCALL) ? REG_A0 : rt;

  mem_op_t     mop;
  logic [2:0]  st;
  logic [31:0] npc, val, outv;
  logic        wr;
  logic [4:0]  idx;

  always_comb begin
    mop = '0;
    mop.lane = off[1:0];
    mop.st_data = b;
    st = ST_OK; npc = pc_r; wr = 1'b0; idx = 5'd0; val = 32'd0; outv = 32'd0;
    halt_nxt = halt_r;
    case (in_cmd)
      CMD_LOAD: begin
        mop.wr_cmd = 1'b1;
        mop.st_data = in_access_data;
      end
      CMD_READ: mop.rd_cmd = 1'b1;
      CMD_EXEC: begin
        if (halt_r) begin
          st = ST_HALT;
        end else if (in_instr_word == 32'd0) begin
          halt_nxt = 1'b1; st = ST_HALT; npc = pc4;
        end else begin
          npc = pc4;
          if (op == OP_RTYPE) begin
            case (fn)
              FN_JR: npc = a;
              FN_ADD, FN_ADDU: begin wr = 1'b1; idx = rd; val = a + b; end
              FN_SUB, FN_SUBU: begin wr = 1'b1; idx = rd; val = a - b; end
              FN_AND: begin wr = 1'b1; idx = rd; val = a & b; end
              FN_SYSCALL: begin
                if (v0 == SYS_EXIT) begin
                  halt_nxt = 1'b1; st = ST_HALT;
                end else if (v0 == SYS_PDEC) begin
                  st = ST_PDEC; outv = a0;
                end else if (v0 == SYS_PHEX) begin
                  st = ST_PHEX; outv = a0;
                end
              end
              default: ;
            endcase
          end else if (op == OP_J || op == OP_JAL) begin
            npc = {pc4[31:28], in_instr_word[25:0], 2'b00};
            if (op == OP_JAL) begin wr = 1'b1; idx = REG_RA; val = pc4; end
          end else begin
            case (op)
              OP_BGTZ: if (!a[31] && a != 32'd0) npc = pc4 + {simm[29:0], 2'b00};
              OP_ADDI, OP_ADDIU: begin wr = 1'b1; idx = rt; val = a + simm; end
              OP_ORI: begin wr = 1'b1; idx = rt; val = a | {16'd0, in_instr_word[15:0]}; end
              OP_LUI: begin wr = 1'b1; idx = rt; val = {in_instr_word[15:0], 16'd0}; end
              OP_LB: begin wr = 1'b1; idx = rt; mop.ld_b = 1'b1; end
              OP_LW: begin wr = 1'b1; idx = rt; mop.ld_w = 1'b1; end
              OP_SB: mop.st_b = 1'b1;
              OP_SW: mop.st_w = 1'b1;
              default: st = ST_UNSP;
            endcase
          end
          if (wr && idx == 5'd0) begin wr = 1'b0; idx = 5'd0; val = 32'd0; end
        end
      end
      default: ;
    endcase
  end

  // ---------------- data memory
  logic [AW-1:0] rd_addr;
  logic          m_we;
  logic [AW-1:0] m_waddr;
  logic [31:0]   m_wdata, m_rdata, cur_word;
  assign rd_addr = off[AW+1:2];

  msie_dmem #(.DATA_WORDS(DATA_WORDS), .AW(AW)) u_dmem (
    .clk(clk), .re(acc), .raddr(rd_addr), .rdata(m_rdata),
    .we(m_we), .waddr(m_waddr), .wdata(m_wdata)
  );

  // stage 2: merge with forwarded word
  assign cur_word = s2_fwd_v_r ? s2_fwd_r : m_rdata;

  logic [4:0]  sh;
  logic [7:0]  byte_v;
  logic        s2_fire;
  assign sh = {s2_op_r.lane, 3'b000};
  assign byte_v = 8'(cur_word >> sh);
  assign s2_fire = s2_v_r && adv2;

  always_comb begin
    m_we = 1'b0; m_waddr = s2_addr_r; m_wdata = s2_op_r.st_data;
    if (clr_r) begin
      m_we = 1'b1; m_waddr = clr_cnt_r[AW-1:0]; m_wdata = 32'd0;
    end else if (s2_fire) begin
      if (s2_op_r.wr_cmd || s2_op_r.st_w) begin
        m_we = 1'b1;
      end else if (s2_op_r.st_b) begin
        m_we = 1'b1;
        m_wdata = (cur_word & ~(32'hff << sh)) | ({24'd0, s2_op_r.st_data[7:0]} << sh);
      end
    end
  end

  assign ld_word = cur_word;
  assign ld_val  = s2_op_r.ld_b ? {{24{byte_v[7]}}, byte_v} : ld_word;
  assign wb_we   = s2_fire && s2_wr_r;
  assign wb_idx  = s2_idx_r;
  assign wb_val  = (s2_op_r.ld_b || s2_op_r.ld_w) ? ld_val : s2_val_r;

  // register hazard: stage 1 reads forwarded through regfile write-through,
  // but only when stage 2 writes this cycle; stall in_ready otherwise not needed
  // since stage 2 always retires when stage 1 accepts (adv2 shared).

  // ---------------- PC, halt, config, clear pass
  always_comb begin
    pc_nxt = pc_r;
    if (acc && in_cmd == CMD_EXEC) pc_nxt = npc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= StartPcRst;
      data_base_r <= DataBaseRst;
      halt_r      <= 1'b0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      s2_v_r      <= 1'b0;
      o_v_r       <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(DATA_WORDS - 1)) clr_r <= 1'b0;
      end
      if (acc) begin
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
      end
      if (cfg_we) begin
        if (cfg_index == 1'(IdxDataBase)) data_base_r <= cfg_wdata;
        else pc_r <= cfg_wdata;
      end
      if (adv2) s2_v_r <= acc;
      if (adv2) o_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s2_op_r    <= mop;
      s2_addr_r  <= rd_addr;
      s2_st_r    <= st;
      s2_npc_r   <= npc;
      s2_wr_r    <= wr;
      s2_idx_r   <= idx;
      s2_val_r   <= val;
      s2_outv_r  <= outv;
      s2_fwd_v_r <= m_we && m_waddr == rd_addr;
      s2_fwd_r   <= m_wdata;
    end
    if (s2_fire) begin
      o_st_r   <= s2_st_r;
      o_npc_r  <= s2_npc_r;
      o_wr_r   <= s2_wr_r;
      o_idx_r  <= s2_idx_r;
      // a load aimed at r0 reports no value
      o_val_r  <= s2_wr_r ? wb_val : 32'd0;
      o_mw_r   <= s2_op_r.wr_cmd || s2_op_r.st_w || s2_op_r.st_b;
      o_outv_r <= s2_op_r.rd_cmd ? cur_word : s2_outv_r;
    end
  end

  assign out_valid       = o_v_r;
  assign out_status      = o_st_r;
  assign out_next_pc     = o_npc_r;
  assign out_reg_written = o_wr_r;
  assign out_reg_index   = o_idx_r;
  assign out_reg_value   = o_val_r;
  assign out_mem_written = o_mw_r;
  assign out_out_value   = o_outv_r;

  // load result not yet in regfile when the next request reads it: the
  // regfile write-through covers it because stage 2 retires in the same edge.
  `CHK_ALWAYS(a_no_accept_clr, !(clr_r && in_ready), "request taken during clear")
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_next_pc),
            "result dropped under stall")
  `CHK_ALWAYS(a_r0_quiet, !(out_valid && out_reg_written && out_reg_index == 5'd0),
              "write to r0 reported")
endmodule

@@ rtl/core/msie_regfile.sv @@
// ----------------------------------------------------------------------------
// msie_regfile
// 32 x 32 register file: three read ports, one write port, r0 reads zero.
// Reset clears every entry through valid bits.
// ----------------------------------------------------------------------------
module msie_regfile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  ra_a,
  input  logic [4:0]  ra_b,
  input  logic [4:0]  ra_c,
  output logic [31:0] rd_a,
  output logic [31:0] rd_b,
  output logic [31:0] rd_c,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd
);
  logic [31:0] regs_r [32];
  logic [31:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && wa != 5'd0) begin
      vld_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      regs_r[wa] <= wd;
    end
  end

  // write-through so a same-cycle write is seen by the reader
  function automatic logic [31:0] rd_port(input logic [4:0] a, input logic [31:0] v,
                                          input logic ok, input logic w,
                                          input logic [4:0] wa_i,
                                          input logic [31:0] wd_i);
    logic [31:0] r;
    r = ok ? v : 32'd0;
    if (w && wa_i == a) r = wd_i;
    if (a == 5'd0) r = 32'd0;
    return r;
  endfunction

  assign rd_a = rd_port(ra_a, regs_r[ra_a], vld_r[ra_a], we, wa, wd);
  assign rd_b = rd_port(ra_b, regs_r[ra_b], vld_r[ra_b], we, wa, wd);
  assign rd_c = rd_port(ra_c, regs_r[ra_c], vld_r[ra_c], we, wa, wd);
endmodule

@@ rtl/core/msie_dmem.sv @@
// ----------------------------------------------------------------------------
// msie_dmem
// Word data memory, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module msie_dmem #(
  parameter int unsigned DATA_WORDS = msie_pkg::DataWordsDef,
  parameter int unsigned AW = $clog2(DATA_WORDS)
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata
);
  logic [31:0] mem_r [DATA_WORDS];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata <= mem_r[raddr];
  end
endmodule

@@ sim/msie_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msie_checker
// Watches the config port and the request and result channels of the execute core,
// keeps its own copy of the architectural state, predicts each result and
// compares it field by field against what the core returns.
// ----------------------------------------------------------------------------
module msie_checker
  import msie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_access_addr,
  input  logic [31:0] in_access_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_next_pc,
  input  logic        out_reg_written,
  input  logic [4:0]  out_reg_index,
  input  logic [31:0] out_reg_value,
  input  logic        out_mem_written,
  input  logic [31:0] out_out_value,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    status_t     status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [31:0] out_value;
  } retire_t;

  logic [31:0] start_pc_q;
  logic [31:0] data_base_q;
  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic        halted_q;
  logic [31:0] dmem [DataWordsDef];
  retire_t     expected_retires[$];

  function automatic int unsigned word_of(logic [31:0] addr);
    logic [31:0] off;
    off = addr - data_base_q;
    return (off >> 2) % DataWordsDef;
  endfunction

  function automatic int unsigned lane_of(logic [31:0] addr);
    logic [31:0] off;
    off = addr - data_base_q;
    return off[1:0] * 8;
  endfunction

  // Execute one request against the shadow state and return its retirement.
  function automatic retire_t execute_request(logic [1:0] cmd, logic [31:0] iw,
                                              logic [31:0] aaddr, logic [31:0] adata);
    retire_t     r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, widx;
    logic [31:0] a, b, imm, simm, pc4, ea, wval, byte_v;
    logic        wr;
    int unsigned wi, sh;
    r.status = ST_OK; r.next_pc = pc_q; r.reg_written = 0; r.reg_index = 0;
    r.reg_value = 0; r.mem_written = 0; r.out_value = 0;
    wr = 0; widx = 0; wval = 0;
    case (cmd_t'(cmd))
      CMD_LOAD: begin
        dmem[word_of(aaddr)] = adata;
        r.mem_written = 1;
      end
      CMD_READ: r.out_value = dmem[word_of(aaddr)];
      CMD_EXEC: begin
        if (halted_q) begin
          r.status = ST_HALT;
        end else if (iw == 0) begin
          halted_q = 1;
          r.status = ST_HALT;
          r.next_pc = pc_q + 4;
          pc_q = r.next_pc;
        end else begin
          op = iw[31:26]; rs = iw[25:21]; rt = iw[20:16]; rd = iw[15:11];
          fn = iw[5:0];
          imm = {16'h0, iw[15:0]};
          simm = {{16{iw[15]}}, iw[15:0]};
          a = gpr[rs]; b = gpr[rt];
          pc4 = pc_q + 4;
          r.next_pc = pc4;
          ea = a + simm;
          case (op)
            OP_RTYPE: begin
              case (fn)
                FN_JR: r.next_pc = a;
                FN_ADD, FN_ADDU: begin wr = 1; widx = rd; wval = a + b; end
                FN_SUB, FN_SUBU: begin wr = 1; widx = rd; wval = a - b; end
                FN_AND: begin wr = 1; widx = rd; wval = a & b; end
                FN_SYSCALL: begin
                  if (gpr[REG_V0] == SYS_EXIT) begin
                    halted_q = 1; r.status = ST_HALT;
                  end else if (gpr[REG_V0] == SYS_PDEC) begin
                    r.status = ST_PDEC; r.out_value = gpr[REG_A0];
                  end else if (gpr[REG_V0] == SYS_PHEX) begin
                    r.status = ST_PHEX; r.out_value = gpr[REG_A0];
                  end
                end
                default: ;
              endcase
            end
            OP_J, OP_JAL: begin
              r.next_pc = {pc4[31:28], iw[25:0], 2'b00};
              if (op == OP_JAL) begin wr = 1; widx = REG_RA; wval = pc4; end
            end
            OP_BGTZ: if (!a[31] && a != 0) r.next_pc = pc4 + (simm << 2);
            OP_ADDI, OP_ADDIU: begin wr = 1; widx = rt; wval = a + simm; end
            OP_ORI: begin wr = 1; widx = rt; wval = a | imm; end
            OP_LUI: begin wr = 1; widx = rt; wval = imm << 16; end
            OP_LB: begin
              byte_v = (dmem[word_of(ea)] >> lane_of(ea)) & 32'hff;
              wr = 1; widx = rt; wval = {{24{byte_v[7]}}, byte_v[7:0]};
            end
            OP_LW: begin wr = 1; widx = rt; wval = dmem[word_of(ea)]; end
            OP_SB: begin
              wi = word_of(ea); sh = lane_of(ea);
              dmem[wi] = (dmem[wi] & ~(32'hff << sh)) | ((b & 32'hff) << sh);
              r.mem_written = 1;
            end
            OP_SW: begin dmem[word_of(ea)] = b; r.mem_written = 1; end
            default: r.status = ST_UNSP;
          endcase
          if (wr && widx != 0) begin
            gpr[widx] = wval;
            r.reg_written = 1; r.reg_index = widx; r.reg_value = wval;
          end
          pc_q = r.next_pc;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    retire_t e;
    if (!rst_n) begin
      start_pc_q = StartPcRst;
      data_base_q = DataBaseRst;
      pc_q = StartPcRst;
      halted_q = 0;
      foreach (gpr[i]) gpr[i] = 0;
      foreach (dmem[i]) dmem[i] = 0;
      expected_retires.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(IdxDataBase)) begin
          data_base_q = cfg_wdata;
        end else begin
          start_pc_q = cfg_wdata;
          pc_q = cfg_wdata;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_retires.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_retires.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status); fail_count++;
          end
          if (out_next_pc !== e.next_pc) begin
            $error("next_pc: expected %h actual %h", e.next_pc, out_next_pc); fail_count++;
          end
          if (out_reg_written !== e.reg_written) begin
            $error("reg_written: expected %0d actual %0d", e.reg_written, out_reg_written);
            fail_count++;
          end
          if (out_reg_index !== e.reg_index) begin
            $error("reg_index: expected %0d actual %0d", e.reg_index, out_reg_index);
            fail_count++;
          end
          if (out_reg_value !== e.reg_value) begin
            $error("reg_value: expected %h actual %h", e.reg_value, out_reg_value);
            fail_count++;
          end
          if (out_mem_written !== e.mem_written) begin
            $error("mem_written: expected %0d actual %0d", e.mem_written, out_mem_written);
            fail_count++;
          end
          if (out_out_value !== e.out_value) begin
            $error("out_value: expected %h actual %h", e.out_value, out_out_value);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_retires.push_back(execute_request(in_cmd, in_instr_word,
                                                   in_access_addr, in_access_data));
    end
    pending = expected_retires.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the MIPS subset execute core with a directed program and random
// instruction streams under three address maps, with random stalls on both
// channels; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import msie_pkg::*;

  localparam int CycleLimit = 200000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic [31:0] in_instr_word;
  logic [31:0] in_access_addr;
  logic [31:0] in_access_data;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [31:0] out_next_pc;
  logic        out_reg_written;
  logic [4:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic        out_mem_written;
  logic [31:0] out_out_value;
  int          fail_count;
  int          pending;
  int          cyc = 0;
  logic        calm;
  logic [31:0] cur_base;

  localparam logic [4:0] RegGp = 5'd28;  // holds the data base for memory ops

  mips_subset_instruction_execute_core uut (.*);

  msie_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random backpressure, one long hold-off
  initial begin
    int hold;
    out_ready = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (cyc == 1500) hold = 300;
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, 5'($urandom_range(0, 31)), fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_dest();
    logic [4:0] d;
    do d = 5'($urandom_range(0, 31)); while (d == REG_V0 || d == RegGp);
    return d;
  endfunction

  task automatic send(cmd_t cmd, logic [31:0] iw, logic [31:0] aa = $urandom,
                      logic [31:0] ad = $urandom);
    logic rdy;
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_instr_word <= iw;
    in_access_addr <= aa;
    in_access_data <= ad;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  task automatic exec(logic [31:0] iw);
    send(CMD_EXEC, iw);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_map(logic [31:0] pc, logic [31:0] base);
    cfg_we <= 1; cfg_index <= 0; cfg_wdata <= pc;
    @(posedge clk);
    cfg_index <= 1'(IdxDataBase); cfg_wdata <= base;
    @(posedge clk);
    cfg_we <= 0;
    cur_base = base;
  endtask

  task automatic load_gp();
    exec(enc_i(OP_LUI, 5'd0, RegGp, cur_base[31:16]));
    exec(enc_i(OP_ORI, RegGp, RegGp, cur_base[15:0]));
  endtask

  task automatic send_random();
    int k;
    logic [5:0] op;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      send(CMD_LOAD, $urandom,
           ($urandom_range(0, 3) == 0) ? $urandom : cur_base + $urandom_range(0, 8191));
    end else if (k < 13) begin
      send(CMD_READ, $urandom,
           ($urandom_range(0, 3) == 0) ? $urandom : cur_base + $urandom_range(0, 8191));
    end else if (k < 14) begin
      send(CMD_NOP, $urandom);
    end else if (k < 16) begin
      do op = 6'($urandom_range(1, 63));
      while (op inside {OP_J, OP_JAL, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_ORI, OP_LUI,
                        OP_LB, OP_LW, OP_SB, OP_SW});
      exec({op, 26'($urandom)});
    end else if (k < 18) begin
      op = 6'($urandom_range(0, 63));
      if (!(op inside {FN_JR, FN_SYSCALL, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND}))
        exec(enc_r(5'($urandom), 5'($urandom), pick_dest(), op));
    end else if (k < 21) begin
      // print request: set v0 first, never to the exit code
      exec(enc_i(OP_ADDIU, 5'd0, REG_V0, ($urandom_range(0, 2) == 0) ? 16'd7 :
                 ($urandom_range(0, 1) ? 16'(SYS_PDEC) : 16'(SYS_PHEX))));
      exec(enc_r(5'($urandom), 5'($urandom), 5'($urandom), FN_SYSCALL));
    end else if (k < 45) begin
      op = ($urandom_range(0, 1)) ? (($urandom_range(0, 1)) ? OP_LW : OP_LB)
                                  : (($urandom_range(0, 1)) ? OP_SW : OP_SB);
      if (op == OP_LW || op == OP_LB)
        exec(enc_i(op, RegGp, pick_dest(), 16'($urandom)));
      else
        exec(enc_i(op, RegGp, 5'($urandom), 16'($urandom)));
    end else if (k < 52) begin
      case ($urandom_range(0, 3))
        0: exec({OP_J, 26'($urandom)});
        1: exec({OP_JAL, 26'($urandom)});
        2: exec(enc_r(5'($urandom), 5'($urandom), 5'($urandom), FN_JR));
        default: exec(enc_i(OP_BGTZ, 5'($urandom), 5'($urandom), 16'($urandom)));
      endcase
    end else if (k < 76) begin
      case ($urandom_range(0, 4))
        0: op = FN_ADD;
        1: op = FN_ADDU;
        2: op = FN_SUB;
        3: op = FN_SUBU;
        default: op = FN_AND;
      endcase
      exec(enc_r(5'($urandom), 5'($urandom), pick_dest(), op));
    end else begin
      case ($urandom_range(0, 3))
        0: op = OP_ADDI;
        1: op = OP_ADDIU;
        2: op = OP_ORI;
        default: op = OP_LUI;
      endcase
      exec(enc_i(op, 5'($urandom), pick_dest(), 16'($urandom)));
    end
  endtask

  initial begin
    calm = 0;
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_valid = 0; in_cmd = CMD_EXEC; in_instr_word = 0;
    in_access_addr = 0; in_access_data = 0;
    cur_base = DataBaseRst;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    set_map(StartPcRst, DataBaseRst);

    // directed: arithmetic extremes, r0 write, memory lanes, control flow, prints
    exec(enc_i(OP_ORI, 5'd0, REG_A0, 16'hffff));
    exec(enc_i(OP_LUI, 5'd0, 5'd3, 16'hffff));
    exec(enc_i(OP_ADDIU, 5'd3, 5'd5, 16'h8000));
    exec(enc_i(OP_ADDI, 5'd0, 5'd6, 16'h7fff));
    exec(enc_r(5'd3, REG_A0, 5'd7, FN_ADD));
    exec(enc_r(5'd3, REG_A0, 5'd0, FN_ADDU));
    exec(enc_r(5'd0, REG_A0, 5'd8, FN_SUB));
    exec(enc_r(REG_A0, 5'd3, 5'd9, FN_SUBU));
    exec(enc_r(5'd3, 5'd5, 5'd10, FN_AND));
    send(CMD_LOAD, 0, DataBaseRst + 8, 32'h80ff_7f01);
    send(CMD_LOAD, 0, 32'hffff_ffff, 32'hffff_ffff);
    send(CMD_READ, 0, DataBaseRst + 8, 0);
    load_gp();
    exec(enc_i(OP_LB, RegGp, 5'd12, 16'd9));
    exec(enc_i(OP_LB, RegGp, 5'd13, 16'd11));
    exec(enc_i(OP_LW, RegGp, 5'd14, 16'd10));
    exec(enc_i(OP_SB, RegGp, REG_A0, 16'd13));
    exec(enc_i(OP_SW, RegGp, 5'd3, 16'hfffe));
    send(CMD_READ, 0, DataBaseRst + 12, 0);
    exec(enc_i(OP_BGTZ, REG_A0, 5'd0, 16'hffff));
    exec(enc_i(OP_BGTZ, 5'd3, 5'd0, 16'h0004));
    exec(enc_i(OP_BGTZ, 5'd0, 5'd0, 16'h0004));
    exec({OP_J, 26'h3ff_ffff});
    exec({OP_JAL, 26'h0});
    exec(enc_r(REG_A0, 5'd0, 5'd0, FN_JR));
    exec(enc_i(OP_ADDIU, 5'd0, REG_V0, 16'(SYS_PDEC)));
    exec(enc_r(5'd0, 5'd0, 5'd0, FN_SYSCALL));
    exec(enc_i(OP_ADDIU, 5'd0, REG_V0, 16'(SYS_PHEX)));
    exec(enc_r(5'd0, 5'd0, 5'd0, FN_SYSCALL));
    exec({6'd4, 26'h123_4567});
    exec(enc_r(5'd1, 5'd2, 5'd3, 6'h3f));
    send(CMD_NOP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    for (int i = 0; i < 450; i++) begin
      calm = (i >= 100 && i < 250);
      send_random();
    end
    calm = 0;
    drain();

    set_map(32'h0, 32'h0);
    load_gp();
    for (int i = 0; i < 250; i++) send_random();
    drain();

    set_map(32'hffff_fffc, 32'hffff_ffff);
    load_gp();
    for (int i = 0; i < 250; i++) send_random();

    // exit syscall halts; further execution is frozen, host access still works
    exec(enc_i(OP_ADDIU, 5'd0, REG_V0, 16'(SYS_EXIT)));
    exec(enc_r(5'd0, 5'd0, 5'd0, FN_SYSCALL));
    exec(enc_i(OP_ADDIU, 5'd0, 5'd9, 16'h1234));
    exec(32'h0);
    send(CMD_LOAD, 0, 32'h0, 32'hdead_beef);
    send(CMD_READ, 0, 32'h0, 0);
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/msie_pkg.sv
rtl/core/msie_regfile.sv
rtl/core/msie_dmem.sv
rtl/core/mips_subset_instruction_execute_core.sv
sim/msie_checker.sv
sim/testbench.sv
